// ----- design/energy_admission_check_core_defines.svh -----
// Assertion macros shared by the checker files of the admission check block.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef ENERGY_ADMISSION_CHECK_CORE_DEFINES_SVH
`define ENERGY_ADMISSION_CHECK_CORE_DEFINES_SVH

// same-cycle implication, ignored during reset
`define EAC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, ignored during reset
`define EAC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/eac_pkg.sv -----
// Shared types, sizes and codes of the energy admission check block.
// No dependencies.
package eac_pkg;

   localparam int NUM_NODES        = 16;
   localparam int ENTRIES_PER_NODE = 16;
   localparam int NODE_W           = $clog2(NUM_NODES);
   localparam int SLOT_W           = $clog2(ENTRIES_PER_NODE);
   localparam int TABLE_DEPTH      = NUM_NODES * ENTRIES_PER_NODE;
   localparam int COUNT_W          = 5;
   localparam int OFFSET_W         = 31;
   localparam int THR_W            = 32;
   localparam int ENTRY_W          = OFFSET_W + THR_W;
   localparam int Q_SHIFT          = 14;
   localparam int DIV_W            = 33;
   localparam int DIV_CNT_W        = 6;
   localparam int MUL_A_W          = 18;
   localparam int MUL_B_W          = 33;
   localparam int PROD_W           = MUL_A_W + MUL_B_W;
   localparam int ACC_W            = 56;

   localparam logic [30:0] PERIOD_RESET = 31'd86400;
   localparam logic [15:0] RATE_RESET   = 16'd16384;
   localparam logic signed [MUL_A_W-1:0] Q_ONE = MUL_A_W'(16384);

   // configuration register indexes
   localparam logic CSR_PERIOD = 1'b0;
   localparam logic CSR_RATE   = 1'b1;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_COUNT = 2'd1,
      OP_CHECK = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CAUSE_NONE      = 2'd0,
      CAUSE_ENERGY    = 2'd1,
      CAUSE_OVERLAP   = 2'd2,
      CAUSE_THRESHOLD = 2'd3
   } cause_type;

   // request to the remainder unit
   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [30:0]       divisor;
   } div_req_type;

endpackage

// ----- design/eac_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module eac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/eac_divider.sv -----
// Restoring remainder unit: one dividend bit per cycle.
// Depends on eac_pkg.
module eac_divider import eac_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output logic [30:0] rem,
   output logic        done
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     num_ff, num_in;
   logic [30:0]          rem_ff, rem_in;
   logic [30:0]          div_ff, div_in;
   logic [31:0]          trial;
   logic                 fits;

   // shift in next dividend bit and try a subtract
   assign trial = {rem_ff, num_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_W);
         num_in  = div_req.dividend;
         rem_in  = '0;
         div_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? 31'(trial - {1'b0, div_ff}) : trial[30:0];
         num_in = num_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign rem  = rem_ff;
   assign done = done_ff;

endmodule

// ----- design/eac_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on eac_pkg.
module eac_mul import eac_pkg::*; (
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] mul_a,
   input  logic signed [MUL_B_W-1:0] mul_b,
   output logic signed [PROD_W-1:0]  prod
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- design/energy_admission_check_core.sv -----
// Top level of the energy admission check: sequencer, reservation table, count table.
// Depends on eac_pkg, eac_ram, eac_divider, eac_mul.
//
//   channel  ports                               direction
//   req      req_valid/req_ready + 9 fields      in
//   rsp      rsp_valid/rsp_ready + violation/cause out
//   csr      csr_valid/csr_ready, index, wdata   in
//
// Table writes and count sets do not occupy the sequencer. A check runs up to its result word
// through two remainder passes, the energy test (multiply, then compare), then an address and
// a compare state per table entry walked (registered RAM read) and the reservation tests.
// Reset is synchronous; it clears the counts, the configuration registers and the control state.
// req_ready is low while a check runs; a finished word waits in the rsp register.
module energy_admission_check_core import eac_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // input words
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_operation,
   input  logic [3:0]          req_node,
   input  logic [3:0]          req_slot,
   input  logic [4:0]          req_entry_count,
   input  logic [30:0]         req_reserve_offset,
   input  logic signed [31:0]  req_reserve_threshold,
   input  logic signed [31:0]  req_available_power,
   input  logic [31:0]         req_now_time,
   input  logic [30:0]         req_task_cost,
   // result words
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_violation,
   output logic [1:0]          rsp_cause,
   // configuration
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [31:0]         csr_wdata
);

   typedef enum logic [9:0] {
      ST_IDLE       = 10'b0000000001,
      ST_DIV_S      = 10'b0000000010,
      ST_DIV_E      = 10'b0000000100,
      ST_ENERGY_MUL = 10'b0000001000,
      ST_ENERGY     = 10'b0000010000,
      ST_WALK_ADDR  = 10'b0000100000,
      ST_WALK_CMP   = 10'b0001000000,
      ST_AVAIL_MUL  = 10'b0010000000,
      ST_FINAL      = 10'b0100000000,
      ST_RESP       = 10'b1000000000
   } state_type;

   state_type                 state_ff, state_in;
   logic [30:0]               period_ff, period_in;
   logic [15:0]               rate_ff, rate_in;
   logic [COUNT_W-1:0]        count_ff [NUM_NODES];
   logic [NODE_W-1:0]         node_ff, node_in;
   logic signed [31:0]        power_ff, power_in;
   logic [31:0]               now_ff, now_in;
   logic [30:0]               cost_ff, cost_in;
   logic [30:0]               s_ff, s_in, e_ff, e_in;
   logic signed [ACC_W-1:0]   p_ff, p_in;
   logic [COUNT_W-1:0]        cnt_ff, cnt_in;
   logic [SLOT_W-1:0]         idx_ff, idx_in;
   logic [OFFSET_W-1:0]       rtt_ff, rtt_in;
   logic signed [THR_W-1:0]   thr_ff, thr_in;
   cause_type                 cause_ff, cause_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   cause_type                 rsp_cause_ff, rsp_cause_in;

   logic                      req_fire, is_check, node_ok;
   logic [30:0]               per, half;
   logic signed [MUL_B_W-1:0] s_x, e_x, half_x, per_x, rtt_x;
   logic signed [MUL_B_W-1:0] term_a, term_b, avail_x;
   logic signed [MUL_A_W-1:0] drain, rate_x;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic signed [ACC_W-1:0]   p_calc, avail, thr_q;
   logic                      overlap, hit, last;
   logic [COUNT_W-1:0]        cnt_raw;
   div_req_type               div_req;
   logic [30:0]               div_rem;
   logic                      div_done;
   logic                      wr_en;
   logic [ENTRY_W-1:0]        rd_data;
   logic [OFFSET_W-1:0]       rd_offset;
   logic signed [THR_W-1:0]   rd_thr;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign is_check  = (req_operation == OP_CHECK);

   // period clamped to at least two ticks, day half
   assign per  = (period_ff < 31'd2) ? 31'd2 : period_ff;
   assign half = {1'b0, per[30:1]};

   assign s_x    = $signed({2'b00, s_ff});
   assign e_x    = $signed({2'b00, e_ff});
   assign half_x = $signed({2'b00, half});
   assign per_x  = $signed({2'b00, per});
   assign rtt_x  = $signed({2'b00, rtt_ff});
   assign rate_x = $signed({2'b00, rate_ff});
   assign drain  = Q_ONE - rate_x;

   // drain ticks (term_a) and full-cost ticks (term_b) over the task
   always_comb begin
      if (s_ff <= half) begin
         if (e_ff <= half) begin
            term_a = e_x - s_x;
            term_b = '0;
         end else begin
            term_a = half_x - s_x;
            term_b = e_x - half_x;
         end
      end else begin
         if (e_ff > half) begin
            term_a = '0;
            term_b = e_x - s_x;
         end else begin
            term_a = e_x;
            term_b = per_x - s_x;
         end
      end
   end

   // overlap with the chosen reservation and charge ticks before it
   always_comb begin
      if (e_ff < s_ff) begin
         overlap = (rtt_ff < e_ff) || (s_ff < rtt_ff);
         avail_x = (rtt_ff < half) ? (rtt_x - e_x) : (half_x - e_x);
      end else begin
         overlap = (s_ff <= rtt_ff) && (rtt_ff < e_ff);
         if (e_ff < half && rtt_ff <= half) begin
            avail_x = rtt_x - e_x;
         end else if (e_ff < half) begin
            avail_x = half_x - e_x;
         end else begin
            avail_x = '0;
         end
      end
   end

   // multiplier operand selection
   always_comb begin
      if (state_ff == ST_AVAIL_MUL) begin
         mul_a = rate_x;
         mul_b = avail_x;
      end else begin
         mul_a = drain;
         mul_b = term_a;
      end
   end

   assign p_calc = (ACC_W'(power_ff) <<< Q_SHIFT) - ACC_W'(prod)
                   - (ACC_W'(term_b) <<< Q_SHIFT);
   assign avail  = p_ff + ACC_W'(prod);
   assign thr_q  = ACC_W'(thr_ff) <<< Q_SHIFT;

   assign node_ok   = (32'(node_ff) < NUM_NODES);
   assign cnt_raw   = count_ff[node_ff];
   assign rd_offset = rd_data[ENTRY_W-1 -: OFFSET_W];
   assign rd_thr    = $signed(rd_data[THR_W-1:0]);
   assign hit       = (s_ff <= rd_offset);
   assign last      = (COUNT_W'(idx_ff) + 1'b1) == cnt_ff;

   // remainder unit requests: start offset, then end offset
   always_comb begin
      div_req.divisor  = per;
      div_req.start    = 1'b0;
      div_req.dividend = {1'b0, req_now_time};
      if (state_ff == ST_IDLE) begin
         div_req.start = req_fire && is_check;
      end else if (state_ff == ST_DIV_S) begin
         div_req.start    = div_done;
         div_req.dividend = DIV_W'(now_ff) + DIV_W'(cost_ff);
      end
   end

   assign wr_en = req_fire && (req_operation == OP_WRITE)
                  && (32'(req_node) < NUM_NODES) && (32'(req_slot) < ENTRIES_PER_NODE);

   eac_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ({req_node, req_slot}),
      .wr_data ({req_reserve_offset, req_reserve_threshold}),
      .rd_addr ({node_ff, idx_ff}),
      .rd_data (rd_data)
   );

   eac_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .rem     (div_rem),
      .done    (div_done)
   );

   eac_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      power_in     = power_ff;
      now_in       = now_ff;
      cost_in      = cost_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      p_in         = p_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      rtt_in       = rtt_ff;
      thr_in       = thr_ff;
      cause_in     = cause_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cause_in = rsp_cause_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_check) begin
               node_in  = req_node;
               power_in = req_available_power;
               now_in   = req_now_time;
               cost_in  = req_task_cost;
               state_in = ST_DIV_S;
            end
         end
         ST_DIV_S: begin
            if (div_done) begin
               s_in     = div_rem;
               state_in = ST_DIV_E;
            end
         end
         ST_DIV_E: begin
            if (div_done) begin
               e_in     = div_rem;
               state_in = ST_ENERGY_MUL;
            end
         end
         ST_ENERGY_MUL: begin
            state_in = ST_ENERGY;
         end
         ST_ENERGY: begin
            p_in   = p_calc;
            idx_in = '0;
            cnt_in = (cnt_raw > COUNT_W'(ENTRIES_PER_NODE)) ?
                     COUNT_W'(ENTRIES_PER_NODE) : cnt_raw;
            if (p_calc < 0) begin
               cause_in = CAUSE_ENERGY;
               state_in = ST_RESP;
            end else if (!node_ok || cnt_in == '0) begin
               cause_in = CAUSE_NONE;
               state_in = ST_RESP;
            end else begin
               state_in = ST_WALK_ADDR;
            end
         end
         ST_WALK_ADDR: begin
            state_in = ST_WALK_CMP;
         end
         ST_WALK_CMP: begin
            // first entry is the wrap-around fallback
            if (hit || idx_ff == '0) begin
               rtt_in = rd_offset;
               thr_in = rd_thr;
            end
            if (hit || last) begin
               state_in = ST_AVAIL_MUL;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_WALK_ADDR;
            end
         end
         ST_AVAIL_MUL: begin
            if (overlap) begin
               cause_in = CAUSE_OVERLAP;
               state_in = ST_RESP;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            cause_in = (thr_q > avail) ? CAUSE_THRESHOLD : CAUSE_NONE;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_cause_in = cause_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration registers
   always_comb begin
      period_in = period_ff;
      rate_in   = rate_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_PERIOD) begin
            period_in = csr_wdata[30:0];
         end else begin
            rate_in = csr_wdata[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= PERIOD_RESET;
         rate_ff      <= RATE_RESET;
         rsp_valid_ff <= 1'b0;
         for (int n = 0; n < NUM_NODES; n++) begin
            count_ff[n] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire && req_operation == OP_COUNT && 32'(req_node) < NUM_NODES) begin
            count_ff[req_node] <= req_entry_count;
         end
      end
      node_ff      <= node_in;
      power_ff     <= power_in;
      now_ff       <= now_in;
      cost_ff      <= cost_in;
      s_ff         <= s_in;
      e_ff         <= e_in;
      p_ff         <= p_in;
      cnt_ff       <= cnt_in;
      idx_ff       <= idx_in;
      rtt_ff       <= rtt_in;
      thr_ff       <= thr_in;
      cause_ff     <= cause_in;
      rsp_cause_ff <= rsp_cause_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cause     = rsp_cause_ff;
   assign rsp_violation = (rsp_cause_ff != CAUSE_NONE);

endmodule

// ----- design/eac_checker.sv -----
// Port-level checks for the energy admission check top level, bound to it.
// Depends on eac_pkg and energy_admission_check_core_defines.svh.
`include "energy_admission_check_core_defines.svh"

module eac_checker import eac_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_operation,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_violation,
   input logic [1:0]  rsp_cause
);

   // a stalled result word holds
   `EAC_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_cause) && $stable(rsp_violation), "result word changed while stalled")

   // violation flag agrees with the cause code
   `EAC_ASSERT_IMP(a_flag_cause, rsp_valid, rsp_violation == (rsp_cause != CAUSE_NONE), "violation flag and cause disagree")

   // an accepted check holds off further input words
   `EAC_ASSERT_NXT(a_check_busy, req_valid && req_ready && req_operation == OP_CHECK, !req_ready, "ready after a check was accepted")

endmodule

bind energy_admission_check_core eac_checker u_eac_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_operation (req_operation),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_violation (rsp_violation),
   .rsp_cause     (rsp_cause)
);

// ----- tb/tb.sv -----
// Self-checking testbench for the energy admission check block.
// Depends on eac_pkg and energy_admission_check_core; drives all three channels.
`timescale 1ns / 100ps

module tb;
   import eac_pkg::*;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int SETTLE_CYCLES  = 160;
   localparam int HOLD_CYCLES    = 400;
   localparam int WORDS_PER_SET  = 320;

   // admission predictor plus queue of expected result words
   class admission_scoreboard;
      logic [30:0] period_reg;
      logic [15:0] rate_reg;
      longint      slot_offset[16][16];
      longint      slot_thresh[16][16];
      bit          slot_written[16][16];
      int          node_count[16];
      cause_type   expected_q[$];
      int          mismatches;
      int          cause_seen[4];
      int          results;

      function new();
         period_reg = PERIOD_RESET;
         rate_reg   = RATE_RESET;
         mismatches = 0;
         results    = 0;
         foreach (node_count[n]) node_count[n] = 0;
         foreach (cause_seen[c]) cause_seen[c] = 0;
         foreach (slot_written[n, s]) slot_written[n][s] = 0;
      endfunction

      function void set_reg(logic idx, logic [31:0] data);
         if (idx == CSR_PERIOD) period_reg = data[30:0];
         else rate_reg = data[15:0];
      endfunction

      // leading run of written slots, bounds legal entry counts
      function int written_prefix(int nd);
         int run;
         run = 0;
         while (run < 16 && slot_written[nd][run]) run++;
         return run;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function cause_type predict(logic [3:0] nd, logic signed [31:0] pw, logic [31:0] nw,
                                  logic [30:0] cst);
         longint per, half, rate_q, drain, st, en, energy, rt, thr, avail, q;
         int cnt;
         bit hit;
         q = longint'(Q_ONE);
         per = (period_reg < 2) ? 2 : longint'(period_reg);
         half = per / 2;
         rate_q = longint'(rate_reg);
         drain = q - rate_q;
         st = longint'(nw) % per;
         en = (longint'(nw) + longint'(cst)) % per;
         energy = longint'(pw) * q;
         // energy spent over the task, day part partly offset by harvest
         if (st <= half) begin
            if (en <= half) energy -= drain * (en - st);
            else energy -= drain * (half - st) + q * (en - half);
         end else begin
            if (en > half) energy -= q * (en - st);
            else energy -= drain * en + q * (per - st);
         end
         if (energy < 0) return CAUSE_ENERGY;
         cnt = node_count[nd];
         if (cnt > 16) cnt = 16;
         if (cnt == 0) return CAUSE_NONE;
         // first reservation at or after the start, else wrap to slot 0
         hit = 0;
         rt = slot_offset[nd][0];
         thr = slot_thresh[nd][0];
         for (int i = 0; i < cnt; i++) begin
            if (!hit && st <= slot_offset[nd][i]) begin
               hit = 1;
               rt = slot_offset[nd][i];
               thr = slot_thresh[nd][i];
            end
         end
         thr *= q;
         if (en < st) begin
            if (rt < en || st < rt) return CAUSE_OVERLAP;
            avail = (rt < half) ? energy + rate_q * (rt - en) : energy + rate_q * (half - en);
         end else begin
            if (st <= rt && rt < en) return CAUSE_OVERLAP;
            if (en < half && rt <= half) avail = energy + rate_q * (rt - en);
            else if (en < half) avail = energy + rate_q * (half - en);
            else avail = energy;
         end
         return (thr > avail) ? CAUSE_THRESHOLD : CAUSE_NONE;
      endfunction

      // accepted input word: update tables or queue a prediction
      function void note_word(logic [1:0] op, logic [3:0] nd, logic [3:0] sl, logic [4:0] cnt,
                              logic [30:0] off, logic signed [31:0] thr,
                              logic signed [31:0] pw, logic [31:0] nw, logic [30:0] cst);
         case (op)
            OP_WRITE: begin
               slot_offset[nd][sl] = longint'(off);
               slot_thresh[nd][sl] = longint'(thr);
               slot_written[nd][sl] = 1;
            end
            OP_COUNT: node_count[nd] = cnt;
            OP_CHECK: expected_q.push_back(predict(nd, pw, nw, cst));
            default: ;
         endcase
      endfunction

      task report(string what);
         $display("MISMATCH @%0t: %s", $time, what);
         mismatches++;
      endtask

      task check_result(logic viol, logic [1:0] cause);
         cause_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result word with nothing expected (cause %0d)", cause));
            return;
         end
         want = expected_q.pop_front();
         results++;
         cause_seen[want]++;
         if (viol !== (want != CAUSE_NONE))
            report($sformatf("violation %b, expected %b", viol, want != CAUSE_NONE));
         if (cause !== want)
            report($sformatf("cause %0d, expected %s", cause, want.name()));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_operation = '0;
   logic [3:0]         req_node = '0;
   logic [3:0]         req_slot = '0;
   logic [4:0]         req_entry_count = '0;
   logic [30:0]        req_reserve_offset = '0;
   logic signed [31:0] req_reserve_threshold = '0;
   logic signed [31:0] req_available_power = '0;
   logic [31:0]        req_now_time = '0;
   logic [30:0]        req_task_cost = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_violation;
   logic [1:0]         rsp_cause;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_index = 1'b0;
   logic [31:0]        csr_wdata = '0;

   admission_scoreboard sb = new();
   bit sender_gaps   = 1'b0;
   bit receiver_gaps = 1'b0;
   bit hold_request  = 1'b0;
   int words_sent    = 0;
   int quiet_cycles  = 0;

   energy_admission_check_core dut (.*);

   always #6 clock = ~clock;

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_violation, rsp_cause);
   end

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", quiet_cycles);
         $display("energy_admission_check_core test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (receiver_gaps && $urandom_range(0, 6) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task send_word(logic [1:0] op, logic [3:0] nd, logic [3:0] sl, logic [4:0] cnt,
                  logic [30:0] off, logic signed [31:0] thr, logic signed [31:0] pw,
                  logic [31:0] nw, logic [30:0] cst);
      req_valid             <= 1'b1;
      req_operation         <= op;
      req_node              <= nd;
      req_slot              <= sl;
      req_entry_count       <= cnt;
      req_reserve_offset    <= off;
      req_reserve_threshold <= thr;
      req_available_power   <= pw;
      req_now_time          <= nw;
      req_task_cost         <= cst;
      do @(posedge clock); while (!req_ready);
      sb.note_word(op, nd, sl, cnt, off, thr, pw, nw, cst);
      words_sent++;
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // unused fields carry random junk
   task send_entry(int nd, int sl, longint off, longint thr);
      send_word(OP_WRITE, nd, sl, $urandom(), off, thr, $urandom(), $urandom(), $urandom());
   endtask

   task send_count(int nd, int cnt);
      send_word(OP_COUNT, nd, $urandom(), cnt, $urandom(), $urandom(), $urandom(), $urandom(),
                $urandom());
   endtask

   task send_check(int nd, longint pw, longint nw, longint cst);
      send_word(OP_CHECK, nd, $urandom(), $urandom(), $urandom(), $urandom(), pw, nw, cst);
   endtask

   task wait_results();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task csr_write(logic idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // legal entry count: never reaches past the written slots
   function int legal_count(int nd);
      int run;
      run = sb.written_prefix(nd);
      return (run == 16) ? $urandom_range(0, 31) : $urandom_range(0, run);
   endfunction

   task directed_words();
      longint thr;
      for (int i = 0; i < 16; i++) begin
         thr = (i == 3) ? 64'sh7fffffff : (i == 4) ? -64'sh80000000 : i * 1000;
         send_entry(0, i, i * 5000, thr);
      end
      send_count(0, 31);                                     // clamped to a full table
      send_check(0, 100000, 2000, 500);                      // clear before slot 1
      send_check(0, 100000, 4800, 1000);                     // runs into slot 1
      send_check(0, -64'sh80000000, 0, 0);                   // energy short
      send_check(0, 64'sh7fffffff, 32'hffffffff, 31'h7fffffff); // long task, top values
      send_check(0, 50000, 80000, 200);                      // past last entry, wraps
      send_check(0, 50000, 50000, 100);                      // night, on a reservation
      send_check(0, 90000, 14000, 900);                      // threshold at maximum
      send_word(2'd3, 4'hf, 4'hf, 5'h1f, '1, '1, '1, '1, '1); // unknown op, ignored
      send_count(0, 0);
      send_check(0, 10, 100, 5);                             // empty table
   endtask

   // well-formed: sorted table for one node, its count, then checks
   task table_run(longint per);
      int nd, k, n;
      longint step, off, span, half;
      nd = $urandom_range(0, 15);
      k = $urandom_range(1, 16);
      half = per / 2;
      span = (per > 64'd1073741824) ? 64'd1073741824 : per;
      step = per / (k + 1);
      if (step < 1) step = 1;
      off = $urandom_range(0, int'(step));
      for (int i = 0; i < k; i++) begin
         if (off > 64'h7fffffff) off = 64'h7fffffff;
         send_entry(nd, i, off, longint'($urandom_range(0, int'(span))) - span / 8);
         off += $urandom_range(0, int'(step));
      end
      send_count(nd, (k == 16 && $urandom_range(0, 3) == 0) ? $urandom_range(17, 31) : k);
      n = $urandom_range(2, 6);
      repeat (n) begin
         send_check(nd,
            ($urandom_range(0, 6) == 0) ? longint'($urandom()) :
               longint'($urandom_range(0, int'(span))),
            $urandom(),
            ($urandom_range(0, 3) == 0) ? longint'($urandom() & 32'h7fffffff) :
               longint'($urandom_range(0, int'(half))));
      end
   endtask

   // noise: stray writes, count sets, free checks and unknown ops
   task noise_word();
      int nd;
      nd = $urandom_range(0, 15);
      case ($urandom_range(0, 3))
         0: send_entry(nd, $urandom_range(0, 15), $urandom() & 32'h7fffffff, $urandom());
         1: send_count(nd, legal_count(nd));
         2: send_check(nd, $urandom(), $urandom(), $urandom() & 32'h7fffffff);
         default: send_word(2'd3, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                            $urandom(), $urandom(), $urandom());
      endcase
   endtask

   logic [31:0] set_period[6] = '{32'd86400, 32'd2, 32'd1000, 32'h7fffffff, 32'd1, 32'd5000};
   logic [31:0] set_rate[6]   = '{32'd16384, 32'd0, 32'd65535, 32'd12000, 32'd30000, 32'd20000};

   initial begin
      longint per;
      int target;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int ph = 0; ph < 6; ph++) begin
         wait_results();
         repeat (SETTLE_CYCLES) @(posedge clock);
         csr_write(CSR_PERIOD, set_period[ph]);
         csr_write(CSR_RATE, set_rate[ph]);
         per = (set_period[ph][30:0] < 2) ? 2 : longint'(set_period[ph][30:0]);
         if (ph == 0) directed_words();
         if (ph == 1) hold_request = 1'b1;
         target = words_sent + WORDS_PER_SET;
         while (words_sent < target) begin
            sender_gaps = (ph < 5) && ($urandom_range(0, 3) != 0);
            receiver_gaps = (ph < 5) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4)) noise_word();
            else table_run(per);
            if ($urandom_range(0, 25) == 0) wait_results();
         end
      end
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d words over 6 period/rate settings; checked %0d admission results",
               words_sent, sb.results);
      $display("  outcomes: %0d clear, %0d energy short, %0d overlap, %0d threshold unmet",
               sb.cause_seen[CAUSE_NONE], sb.cause_seen[CAUSE_ENERGY],
               sb.cause_seen[CAUSE_OVERLAP], sb.cause_seen[CAUSE_THRESHOLD]);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("energy_admission_check_core test passed");
      else
         $display("energy_admission_check_core test failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+design
design/eac_pkg.sv
design/eac_ram.sv
design/eac_divider.sv
design/eac_mul.sv
design/energy_admission_check_core.sv
design/eac_checker.sv
tb/tb.sv
